>>> design/brm_pkg.sv
// ============================================================================
// brm_pkg - ballistic RMS meter shared definitions
// Request codes, field widths and fixed-point constants used by the meter
// and its port checker.
// ============================================================================
package brm_pkg;

  // Default widths of the sample and of the filter levels
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LEVEL_BITS_DEF  = 32;

  // Ballistic coefficient register, unsigned Q0.24
  localparam int OMEGA_W = 23;
  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 23'd3397;
  localparam logic [OMEGA_W-1:0] OMEGA_MAX   = 23'd4194304;  // 0.25

  // Filter coefficient: up to 4*omega = 1.0 in Q1.24
  localparam int COEF_W    = 25;
  localparam int COEF_FRAC = 24;

  // Output level, unsigned Q1.23
  localparam int RMS_W = 24;

  // Square root operand: 2*level moved to Q2.46
  localparam int SQRT_ARG_W = 48;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_EOB    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

endpackage

>>> design/ballistic_rms_meter.sv
// ============================================================================
// ballistic_rms_meter - RMS level meter with meter ballistics
// Squares audio samples into a fast one-pole filter, steps a slow filter
// after each group of four samples, and keeps a peak-held RMS level.
// ============================================================================
// One request is handled at a time. A read's level waits in an output
// register. A sample keeps the block busy for the square and the fast
// filter update, and also for the slow filter update when it completes a
// group of four; these use the shared shift-add multiplier, which takes
// MB = max(SAMPLE_BITS, 25) steps and handles one multiplier bit per
// cycle. An end of block runs the bit-serial square root, which retires
// two radicand bits per cycle, and then updates the held level. While the
// block is idle, a read transfer is held off only while the previous level
// is still waiting to be taken. The coefficient register accepts a write
// whenever the block is idle.
module ballistic_rms_meter #(
  parameter int SAMPLE_BITS = brm_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS  = brm_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  // level channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brm_pkg::RMS_W-1:0]     out_rms_level,
  // coefficient write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brm_pkg::OMEGA_W-1:0]   cfg_omega
);

  localparam int FRAC_BITS = LEVEL_BITS - 2;
  localparam int MUL_A_W   = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
  localparam int MUL_B_W   = (SAMPLE_BITS > brm_pkg::COEF_W) ? SAMPLE_BITS
                                                              : brm_pkg::COEF_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CNT_W     = $clog2(MUL_B_W);
  // square alignment to Q2.F
  localparam int SQ_SH     = 2 * (SAMPLE_BITS - 1) - FRAC_BITS;
  localparam int SQ_SHR    = (SQ_SH > 0) ? SQ_SH : 0;
  localparam int SQ_SHL    = (SQ_SH < 0) ? -SQ_SH : 0;
  localparam int SQ_EXT_W  = PROD_W + SQ_SHL;
  // 2*level in Q2.46
  localparam int ARG_SH    = brm_pkg::SQRT_ARG_W + 1 - LEVEL_BITS;
  localparam int ARG_EXT_W = LEVEL_BITS + ARG_SH;
  localparam int ROOT_W    = brm_pkg::RMS_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int RAD_W     = brm_pkg::SQRT_ARG_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (brm_pkg::COEF_FRAC - 1);
  localparam logic [CNT_W-1:0]  MUL_LAST   = CNT_W'(MUL_B_W - 1);
  localparam logic [CNT_W-1:0]  SQRT_LAST  = CNT_W'(ROOT_W - 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SQ_MUL   = 10'b0000000010,
    S_FAST_SET = 10'b0000000100,
    S_FAST_MUL = 10'b0000001000,
    S_FAST_UPD = 10'b0000010000,
    S_SLOW_SET = 10'b0000100000,
    S_SLOW_MUL = 10'b0001000000,
    S_SLOW_UPD = 10'b0010000000,
    S_SQRT     = 10'b0100000000,
    S_HOLD     = 10'b1000000000
  } state_t;

  // control and state registers
  state_t                         state_r, state_nxt;
  logic [brm_pkg::OMEGA_W-1:0]    omega_r, omega_nxt;
  logic [LEVEL_BITS-1:0]          fast_r, fast_nxt;
  logic [LEVEL_BITS-1:0]          fast_saved_r, fast_saved_nxt;
  logic [LEVEL_BITS-1:0]          slow_r, slow_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic [ROOT_W-1:0]              held_r, held_nxt;
  logic                           pending_r, pending_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  // datapath registers
  logic [brm_pkg::RMS_W-1:0]      out_level_r, out_level_nxt;
  logic [MUL_A_W-1:0]             mul_a_r, mul_a_nxt;
  logic [MUL_B_W-1:0]             mul_b_r, mul_b_nxt;
  logic [PROD_W-1:0]              prod_r, prod_nxt;
  logic                           rnd_r, rnd_nxt;
  logic                           up_r, up_nxt;
  logic [RAD_W-1:0]               rad_r, rad_nxt;
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic [ROOT_W-1:0]              root_r, root_nxt;

  logic                           in_xfer;
  logic                           out_free;
  logic                           mul_run;
  logic                           mul_last;
  logic [SAMPLE_BITS-1:0]         mag;
  logic [brm_pkg::OMEGA_W-1:0]    omega_eff;
  logic [brm_pkg::COEF_W-1:0]     coef_sel;
  logic [PROD_W-1:0]              mul_add;
  logic [PROD_W-1:0]              mul_rnd;
  logic [SQ_EXT_W-1:0]            sq_ext;
  logic [LEVEL_BITS-1:0]          sq_lvl;
  logic [LEVEL_BITS-1:0]          flt_lvl;
  logic [LEVEL_BITS-1:0]          flt_tgt;
  logic                           flt_up;
  logic [LEVEL_BITS-1:0]          flt_diff;
  logic [LEVEL_BITS-1:0]          upd_lvl;
  logic [LEVEL_BITS-1:0]          upd_delta;
  logic [LEVEL_BITS-1:0]          upd_new;
  logic [ARG_EXT_W-1:0]           arg_ext;
  logic [REM_W-1:0]               rem_sh;
  logic [REM_W-1:0]               trial;
  logic                           trial_ok;

  // handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) ||
                     (in_req_type == brm_pkg::REQ_READ && !out_free);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_rms_level = out_level_r;

  // coefficient limited to 0.25
  assign omega_eff = (omega_r > brm_pkg::OMEGA_MAX) ? brm_pkg::OMEGA_MAX : omega_r;

  // sample magnitude; the most negative code gives 2^(SAMPLE_BITS-1)
  assign mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;

  // shift-add multiplier, one multiplier bit per cycle, MSB first
  assign mul_run  = (state_r == S_SQ_MUL) || (state_r == S_FAST_MUL) ||
                    (state_r == S_SLOW_MUL);
  assign mul_last = (cnt_r == MUL_LAST);
  assign mul_add  = mul_b_r[MUL_B_W-1] ? PROD_W'(mul_a_r) : '0;
  assign mul_rnd  = (mul_last && rnd_r) ? ROUND_HALF : '0;

  // square moved to Q2.F
  assign sq_ext = (SQ_EXT_W'(prod_r) << SQ_SHL) >> SQ_SHR;
  assign sq_lvl = sq_ext[LEVEL_BITS-1:0];

  // filter setup: distance from level to target
  assign flt_lvl  = (state_r == S_SLOW_SET) ? slow_r : fast_r;
  assign flt_tgt  = (state_r == S_SLOW_SET) ? fast_r : sq_lvl;
  assign flt_up   = (flt_tgt >= flt_lvl);
  assign flt_diff = flt_up ? (flt_tgt - flt_lvl) : (flt_lvl - flt_tgt);
  assign coef_sel = (state_r == S_SLOW_SET) ? {omega_eff, 2'b00} : {2'b00, omega_eff};

  // filter update with the rounded product
  assign upd_lvl   = (state_r == S_SLOW_UPD) ? slow_r : fast_r;
  assign upd_delta = prod_r[brm_pkg::COEF_FRAC +: LEVEL_BITS];
  assign upd_new   = up_r ? (upd_lvl + upd_delta) : (upd_lvl - upd_delta);

  // square root operand and restoring step, two radicand bits per cycle
  assign arg_ext  = {slow_r, {ARG_SH{1'b0}}};
  assign rem_sh   = {rem_r[ROOT_W-1:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign trial_ok = (rem_sh >= trial);

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    omega_nxt      = omega_r;
    fast_nxt       = fast_r;
    fast_saved_nxt = fast_saved_r;
    slow_nxt       = slow_r;
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    pending_nxt    = pending_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_level_nxt  = out_level_r;
    cnt_nxt        = cnt_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    prod_nxt       = prod_r;
    rnd_nxt        = rnd_r;
    up_nxt         = up_r;
    rad_nxt        = rad_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;

    if (cfg_valid && cfg_ready) begin
      omega_nxt = cfg_omega;
    end

    // multiplier step
    if (mul_run) begin
      prod_nxt  = {prod_r[PROD_W-2:0], 1'b0} + mul_add + mul_rnd;
      mul_b_nxt = {mul_b_r[MUL_B_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_req_type)
            brm_pkg::REQ_SAMPLE: begin
              mul_a_nxt = MUL_A_W'(mag);
              mul_b_nxt = MUL_B_W'(mag);
              prod_nxt  = '0;
              rnd_nxt   = 1'b0;
              cnt_nxt   = '0;
              state_nxt = S_SQ_MUL;
            end
            brm_pkg::REQ_EOB: begin
              // drop a partial group
              fast_nxt  = fast_saved_r;
              phase_nxt = 2'd0;
              rad_nxt   = arg_ext[RAD_W-1:0];
              rem_nxt   = '0;
              root_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = S_SQRT;
            end
            brm_pkg::REQ_READ: begin
              out_valid_nxt = 1'b1;
              out_level_nxt = held_r;
              pending_nxt   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SQ_MUL: begin
        if (mul_last) begin
          state_nxt = S_FAST_SET;
        end
      end
      S_FAST_SET, S_SLOW_SET: begin
        up_nxt    = flt_up;
        mul_a_nxt = MUL_A_W'(flt_diff);
        mul_b_nxt = MUL_B_W'(coef_sel);
        prod_nxt  = '0;
        rnd_nxt   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = (state_r == S_SLOW_SET) ? S_SLOW_MUL : S_FAST_MUL;
      end
      S_FAST_MUL: begin
        if (mul_last) begin
          state_nxt = S_FAST_UPD;
        end
      end
      S_FAST_UPD: begin
        fast_nxt  = upd_new;
        phase_nxt = phase_r + 1'b1;
        state_nxt = (phase_r == 2'd3) ? S_SLOW_SET : S_IDLE;
      end
      S_SLOW_MUL: begin
        if (mul_last) begin
          state_nxt = S_SLOW_UPD;
        end
      end
      S_SLOW_UPD: begin
        slow_nxt       = upd_new;
        fast_saved_nxt = fast_r;
        state_nxt      = S_IDLE;
      end
      S_SQRT: begin
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (trial_ok) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // root is at most 24 bits, so the output never needs clipping
        if (pending_r) begin
          held_nxt    = root_r;
          pending_nxt = 1'b0;
        end else if (root_r > held_r) begin
          held_nxt = root_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and level state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      omega_r      <= brm_pkg::OMEGA_RESET;
      fast_r       <= '0;
      fast_saved_r <= '0;
      slow_r       <= '0;
      phase_r      <= '0;
      held_r       <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      omega_r      <= omega_nxt;
      fast_r       <= fast_nxt;
      fast_saved_r <= fast_saved_nxt;
      slow_r       <= slow_nxt;
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      pending_r    <= pending_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    prod_r      <= prod_nxt;
    rnd_r       <= rnd_nxt;
    up_r        <= up_nxt;
    rad_r       <= rad_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
  end

endmodule

>>> design/brm_checker.sv
// ============================================================================
// brm_checker - port checks for the ballistic RMS meter
// Watches the request, level and coefficient ports over time; bound to
// the meter's top level.
// ============================================================================
module brm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_req_type,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [brm_pkg::RMS_W-1:0] out_rms_level,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  logic read_xfer;
  logic work_xfer;

  assign read_xfer = in_valid && !in_stall && (in_req_type == brm_pkg::REQ_READ);
  assign work_xfer = in_valid && !in_stall &&
                     (in_req_type == brm_pkg::REQ_SAMPLE ||
                      in_req_type == brm_pkg::REQ_EOB);

  // every read transfer shows a level in the next cycle
  a_read_gives_level: assert property (@(posedge clk) disable iff (!rst_n)
    read_xfer |=> out_valid)
    else $error("read transfer not followed by a level");

  // a level only appears in response to a read
  a_level_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(read_xfer))
    else $error("level shown without a read transfer");

  // samples and end of block keep the block busy afterwards
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    work_xfer |=> in_stall && !cfg_ready)
    else $error("block idle right after a sample or end of block");

  // a stalled level holds
  a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rms_level))
    else $error("stalled level changed");

endmodule

bind ballistic_rms_meter brm_checker u_brm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_req_type   (in_req_type),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_rms_level (out_rms_level),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
